@@ hw/rtl/flptw_pkg.sv @@
// ============================================================================
// flptw_pkg
// Shared types, constants and helpers for the four-level page table walker.
// ============================================================================
package flptw_pkg;

  // Field widths.
  localparam int unsigned PhysBits = 52;
  localparam int unsigned PAddrW   = 52;
  localparam int unsigned VAddrW   = 48;
  localparam int unsigned EntryW   = 64;
  localparam int unsigned IdxW     = 9;
  localparam int unsigned LevelW   = 2;
  localparam int unsigned SizeW    = 2;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Address masks; the table mask keeps entry bits PhysBits-1..12.
  localparam logic [PAddrW-1:0] TableMask =
      ((PAddrW'(1) << PhysBits) - PAddrW'(1)) & ~PAddrW'(52'hFFF);
  localparam logic [PAddrW-1:0] GibFrame  = TableMask & ~PAddrW'(52'h3FFF_FFFF);
  localparam logic [PAddrW-1:0] MibFrame  = TableMask & ~PAddrW'(52'h1F_FFFF);
  localparam logic [PAddrW-1:0] GibOffs   = PAddrW'(52'h3FFF_FFFF);
  localparam logic [PAddrW-1:0] MibOffs   = PAddrW'(52'h1F_FFFF);
  localparam logic [PAddrW-1:0] PageOffs  = PAddrW'(52'hFFF);

  // Entry bits.
  localparam int unsigned PresentBit = 0;
  localparam int unsigned HugeBit    = 7;

  // Input item kinds.
  localparam logic ReqTranslate = 1'b0;
  localparam logic ReqResponse  = 1'b1;

  // Result kinds.
  localparam logic KindRead = 1'b0;
  localparam logic KindDone = 1'b1;

  // Page size codes.
  localparam logic [SizeW-1:0] Size4K = 2'd0;
  localparam logic [SizeW-1:0] Size2M = 2'd1;
  localparam logic [SizeW-1:0] Size1G = 2'd2;

  // Walk levels: the level whose entry is awaited.
  localparam logic [LevelW-1:0] LvlPml4 = 2'd0;
  localparam logic [LevelW-1:0] LvlPdpt = 2'd1;
  localparam logic [LevelW-1:0] LvlPd   = 2'd2;
  localparam logic [LevelW-1:0] LvlPt   = 2'd3;

  // Classified item as it travels from the front to the back.
  typedef struct packed {
    logic              is_resp;
    logic [VAddrW-1:0] virt;
    logic [PAddrW-1:0] base;
    logic [EntryW-1:0] data;
  } item_t;

  // One result item.
  typedef struct packed {
    logic              kind;
    logic [PAddrW-1:0] read_addr;
    logic              fault;
    logic [PAddrW-1:0] phys_addr;
    logic [EntryW-1:0] leaf_entry;
    logic [SizeW-1:0]  page_size;
  } result_t;

  // Nine-bit table index of a virtual address at a given level.
  function automatic logic [IdxW-1:0] level_index(logic [VAddrW-1:0] va,
                                                 logic [LevelW-1:0] lvl);
    logic [IdxW-1:0] idx;
    case (lvl)
      LvlPml4: idx = va[47:39];
      LvlPdpt: idx = va[38:30];
      LvlPd:   idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  // Entry address: table base plus index times eight.
  function automatic logic [PAddrW-1:0] entry_addr(logic [PAddrW-1:0] base,
                                                  logic [IdxW-1:0] idx);
    return (base & TableMask) | PAddrW'({idx, 3'b000});
  endfunction

endpackage

@@ hw/rtl/flptw_front.sv @@
// ============================================================================
// flptw_front
// Accepts input items, classifies them and packs them for the queue.
// ============================================================================
module flptw_front (
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic [flptw_pkg::VAddrW-1:0] virt_addr_i,
  input  logic [flptw_pkg::PAddrW-1:0] root_table_i,
  input  logic [flptw_pkg::EntryW-1:0] read_data_i,
  output logic                        push_valid_o,
  output flptw_pkg::item_t            push_item_o,
  input  logic                        push_ready_i
);

  // The front takes an item whenever the queue has room.
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  // Classify the item and reduce the root pointer to its table base.
  always_comb begin
    push_item_o.is_resp = (req_type_i == flptw_pkg::ReqResponse);
    push_item_o.virt    = virt_addr_i;
    push_item_o.base    = root_table_i & flptw_pkg::TableMask;
    push_item_o.data    = read_data_i;
  end

endmodule

@@ hw/rtl/flptw_queue.sv @@
// ============================================================================
// flptw_queue
// Short FIFO of classified items between the front and the back.
// ============================================================================
module flptw_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  flptw_pkg::item_t push_item_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output flptw_pkg::item_t pop_item_o
);

  flptw_pkg::item_t                  slots_q [flptw_pkg::QueueDepth];
  logic [flptw_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [flptw_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [flptw_pkg::QCntW-1:0]       count_q, count_d;
  logic                              push;
  logic                              pop;

  assign push_ready_o = (count_q != flptw_pkg::QCntW'(flptw_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_item_o   = slots_q[rd_ptr_q];

  // Pointer and fill count update; pointers wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == flptw_pkg::QPtrW'(flptw_pkg::QueueDepth - 1)) ?
                 '0 : wr_ptr_q + flptw_pkg::QPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == flptw_pkg::QPtrW'(flptw_pkg::QueueDepth - 1)) ?
                 '0 : rd_ptr_q + flptw_pkg::QPtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + flptw_pkg::QCntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - flptw_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ hw/rtl/flptw_back.sv @@
// ============================================================================
// flptw_back
// Walk state and output register: steps the walk one item at a time.
// ============================================================================
module flptw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_o,
  input  flptw_pkg::item_t   pop_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output flptw_pkg::result_t out_result_o
);

  logic                              busy_q, busy_d;
  logic [flptw_pkg::LevelW-1:0]      level_q, level_d;
  logic [flptw_pkg::VAddrW-1:0]      held_va_q;
  logic                              load_va;
  logic                              out_valid_q;
  flptw_pkg::result_t                result_q, result_d;
  logic                              emit;
  logic                              drop;
  logic                              slot_free;
  logic [flptw_pkg::PAddrW-1:0]      entry_pa;
  logic [flptw_pkg::PAddrW-1:0]      va_ext;
  logic                              present;
  logic                              huge;

  assign slot_free = !out_valid_q || out_ready_i;
  assign entry_pa  = pop_item_i.data[flptw_pkg::PAddrW-1:0];
  assign va_ext    = flptw_pkg::PAddrW'(held_va_q);
  assign present   = pop_item_i.data[flptw_pkg::PresentBit];
  assign huge      = pop_item_i.data[flptw_pkg::HugeBit];

  // A request while busy or a response while idle is dropped.
  assign drop  = pop_item_i.is_resp ? !busy_q : busy_q;
  assign emit  = pop_valid_i && !drop && slot_free;
  assign pop_o = pop_valid_i && (drop || slot_free);

  // Next walk state and the result of the item at the queue head.
  always_comb begin
    busy_d   = busy_q;
    level_d  = level_q;
    load_va  = 1'b0;
    result_d = '0;
    if (!pop_item_i.is_resp) begin
      // New walk: read the top-level entry.
      busy_d             = 1'b1;
      level_d            = flptw_pkg::LvlPml4;
      load_va            = 1'b1;
      result_d.kind      = flptw_pkg::KindRead;
      result_d.read_addr = flptw_pkg::entry_addr(pop_item_i.base,
          flptw_pkg::level_index(pop_item_i.virt, flptw_pkg::LvlPml4));
    end else begin
      result_d.kind = flptw_pkg::KindDone;
      busy_d        = 1'b0;
      level_d       = flptw_pkg::LvlPml4;
      if (level_q == flptw_pkg::LvlPt) begin
        // Last level: the entry comes back raw even when absent.
        result_d.fault      = !present;
        result_d.leaf_entry = pop_item_i.data;
        result_d.phys_addr  = present ?
            ((entry_pa & flptw_pkg::TableMask) | (va_ext & flptw_pkg::PageOffs)) : '0;
      end else if (!present) begin
        result_d.fault = 1'b1;
      end else if (level_q == flptw_pkg::LvlPdpt && huge) begin
        result_d.leaf_entry = pop_item_i.data;
        result_d.page_size  = flptw_pkg::Size1G;
        result_d.phys_addr  =
            (entry_pa & flptw_pkg::GibFrame) | (va_ext & flptw_pkg::GibOffs);
      end else if (level_q == flptw_pkg::LvlPd && huge) begin
        result_d.leaf_entry = pop_item_i.data;
        result_d.page_size  = flptw_pkg::Size2M;
        result_d.phys_addr  =
            (entry_pa & flptw_pkg::MibFrame) | (va_ext & flptw_pkg::MibOffs);
      end else begin
        // Table pointer: read the next level's entry.
        busy_d             = 1'b1;
        level_d            = level_q + flptw_pkg::LevelW'(1);
        result_d.kind      = flptw_pkg::KindRead;
        result_d.read_addr = flptw_pkg::entry_addr(entry_pa,
            flptw_pkg::level_index(held_va_q, level_d));
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      level_q     <= flptw_pkg::LvlPml4;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        busy_q  <= busy_d;
        level_q <= level_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      result_q <= result_d;
      if (load_va) begin
        held_va_q <= pop_item_i.virt;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = result_q;

endmodule

@@ hw/rtl/four_level_page_table_walker_unit.sv @@
// ============================================================================
// four_level_page_table_walker_unit
// Four-level x86-64 page table walker with a decoupled front and back.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid_i/in_ready_o   req_type, virt_addr, root_table,
//                                             read_data
//   out      output     out_valid_o/out_ready_i out_kind, read_addr, fault,
//                                             phys_addr, leaf_entry, page_size
//
// One item per cycle is accepted while the queue has room, and one result per
// cycle can be given while the receiver is ready; the back steps the walk once
// per cycle from a two-entry queue unless the output stalls. An accepted item
// is held in a queue slot, then the walk step registers its result.
// Reset clears the walk state, queue pointers and output valid flag at once.
// A stalled output keeps items in the queue; dropped items leave it even then.
// ============================================================================
module four_level_page_table_walker_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic [flptw_pkg::VAddrW-1:0] virt_addr_i,
  input  logic [flptw_pkg::PAddrW-1:0] root_table_i,
  input  logic [flptw_pkg::EntryW-1:0] read_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         out_kind_o,
  output logic [flptw_pkg::PAddrW-1:0] read_addr_o,
  output logic                         fault_o,
  output logic [flptw_pkg::PAddrW-1:0] phys_addr_o,
  output logic [flptw_pkg::EntryW-1:0] leaf_entry_o,
  output logic [flptw_pkg::SizeW-1:0]  page_size_o
);

  logic               push_valid;
  logic               push_ready;
  flptw_pkg::item_t   push_item;
  logic               pop_valid;
  logic               pop;
  flptw_pkg::item_t   pop_item;
  flptw_pkg::result_t result;

  // Front: accept and classify.
  flptw_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .virt_addr_i  (virt_addr_i),
    .root_table_i (root_table_i),
    .read_data_i  (read_data_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  // Queue between the two halves.
  flptw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_item_o   (pop_item)
  );

  // Back: walk state and output register.
  flptw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_o        (pop),
    .pop_item_i   (pop_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_result_o (result)
  );

  assign out_kind_o   = result.kind;
  assign read_addr_o  = result.read_addr;
  assign fault_o      = result.fault;
  assign phys_addr_o  = result.phys_addr;
  assign leaf_entry_o = result.leaf_entry;
  assign page_size_o  = result.page_size;

endmodule

@@ tb/tb.sv @@
// ============================================================================
// Four-level page table walker testbench
// Drives translate requests and table entry responses into the walker and
// predicts every read request and finished translation in order. The run has
// a directed set of walks, then random walks under three idling patterns.
// ============================================================================
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned MaxReports  = 30;

  // Frame masks of a table pointer, a 1 GiB page and a 2 MiB page.
  localparam logic [flptw_pkg::PAddrW-1:0] EntryBaseMask = 52'hF_FFFF_FFFF_F000;
  localparam logic [flptw_pkg::PAddrW-1:0] GibFrameMask  = 52'hF_FFFF_C000_0000;
  localparam logic [flptw_pkg::PAddrW-1:0] MibFrameMask  = 52'hF_FFFF_FFE0_0000;

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         in_valid_i   = 1'b0;
  logic                         in_ready_o;
  logic                         req_type_i   = flptw_pkg::ReqTranslate;
  logic [flptw_pkg::VAddrW-1:0] virt_addr_i  = '0;
  logic [flptw_pkg::PAddrW-1:0] root_table_i = '0;
  logic [flptw_pkg::EntryW-1:0] read_data_i  = '0;
  logic                         out_valid_o;
  logic                         out_ready_i  = 1'b0;
  logic                         out_kind_o;
  logic [flptw_pkg::PAddrW-1:0] read_addr_o;
  logic                         fault_o;
  logic [flptw_pkg::PAddrW-1:0] phys_addr_o;
  logic [flptw_pkg::EntryW-1:0] leaf_entry_o;
  logic [flptw_pkg::SizeW-1:0]  page_size_o;

  // Predicted walk state.
  logic                         walk_busy = 1'b0;
  logic [flptw_pkg::LevelW-1:0] walk_lvl  = flptw_pkg::LvlPml4;
  logic [flptw_pkg::VAddrW-1:0] walk_va   = '0;

  flptw_pkg::result_t pending_results[$];
  int unsigned send_gap_pct     = 0;
  int unsigned recv_stall_pct   = 0;
  int unsigned cycle_count      = 0;
  int unsigned errors           = 0;
  int unsigned walk_steps       = 0;
  int unsigned dropped_items    = 0;
  int unsigned results_checked  = 0;
  int unsigned pages_4k         = 0;
  int unsigned pages_2m         = 0;
  int unsigned pages_1g         = 0;
  int unsigned walk_faults      = 0;

  four_level_page_table_walker_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .virt_addr_i  (virt_addr_i),
    .root_table_i (root_table_i),
    .read_data_i  (read_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_kind_o   (out_kind_o),
    .read_addr_o  (read_addr_o),
    .fault_o      (fault_o),
    .phys_addr_o  (phys_addr_o),
    .leaf_entry_o (leaf_entry_o),
    .page_size_o  (page_size_o)
  );

  // Clock with a 12 ns period.
  always begin
    #6;
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
  end

  // Random field values.
  function automatic logic [flptw_pkg::VAddrW-1:0] rand_va();
    return flptw_pkg::VAddrW'({$urandom, $urandom});
  endfunction

  function automatic logic [flptw_pkg::PAddrW-1:0] rand_root();
    return flptw_pkg::PAddrW'({$urandom, $urandom});
  endfunction

  function automatic bit rand_bit();
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [flptw_pkg::EntryW-1:0] rand_entry(bit present, bit huge);
    logic [flptw_pkg::EntryW-1:0] entry;
    entry = {$urandom, $urandom};
    entry[flptw_pkg::PresentBit] = present;
    entry[flptw_pkg::HugeBit] = huge;
    return entry;
  endfunction

  // Address of the entry that the given level indexes within a table.
  function automatic logic [flptw_pkg::PAddrW-1:0] table_entry_addr(
      logic [flptw_pkg::PAddrW-1:0] base, logic [flptw_pkg::LevelW-1:0] lvl,
      logic [flptw_pkg::VAddrW-1:0] va);
    logic [8:0] idx;
    idx = 9'(va >> (39 - 9 * int'(lvl)));
    return (base & EntryBaseMask) + flptw_pkg::PAddrW'({idx, 3'b000});
  endfunction

  // Advances the predicted walk by one accepted item. Returns 1 when the item
  // yields a result, which is then written to res.
  function automatic bit predict_walk_step(logic kind, logic [flptw_pkg::VAddrW-1:0] va,
                                           logic [flptw_pkg::PAddrW-1:0] root,
                                           logic [flptw_pkg::EntryW-1:0] data,
                                           output flptw_pkg::result_t res);
    logic [flptw_pkg::PAddrW-1:0] frame;
    res = '0;
    frame = data[flptw_pkg::PAddrW-1:0];
    if (kind == flptw_pkg::ReqTranslate) begin
      if (walk_busy) begin
        dropped_items++;
        return 1'b0;
      end
      walk_busy = 1'b1;
      walk_lvl = flptw_pkg::LvlPml4;
      walk_va = va;
      res.kind = flptw_pkg::KindRead;
      res.read_addr = table_entry_addr(root, flptw_pkg::LvlPml4, va);
      return 1'b1;
    end
    if (!walk_busy) begin
      dropped_items++;
      return 1'b0;
    end
    res.kind = flptw_pkg::KindDone;
    if (walk_lvl == flptw_pkg::LvlPt) begin
      // The last level hands back its entry raw, present or not.
      res.fault = !data[flptw_pkg::PresentBit];
      res.leaf_entry = data;
      res.page_size = flptw_pkg::Size4K;
      if (data[flptw_pkg::PresentBit]) begin
        res.phys_addr = (frame & EntryBaseMask) | flptw_pkg::PAddrW'(walk_va[11:0]);
      end
    end else if (!data[flptw_pkg::PresentBit]) begin
      res.fault = 1'b1;
    end else if (walk_lvl == flptw_pkg::LvlPdpt && data[flptw_pkg::HugeBit]) begin
      res.phys_addr = (frame & GibFrameMask) | flptw_pkg::PAddrW'(walk_va[29:0]);
      res.leaf_entry = data;
      res.page_size = flptw_pkg::Size1G;
    end else if (walk_lvl == flptw_pkg::LvlPd && data[flptw_pkg::HugeBit]) begin
      res.phys_addr = (frame & MibFrameMask) | flptw_pkg::PAddrW'(walk_va[20:0]);
      res.leaf_entry = data;
      res.page_size = flptw_pkg::Size2M;
    end else begin
      // Table pointer: ask for the next level's entry.
      walk_lvl = walk_lvl + 2'd1;
      res.kind = flptw_pkg::KindRead;
      res.read_addr = table_entry_addr(frame, walk_lvl, walk_va);
      return 1'b1;
    end
    walk_busy = 1'b0;
    walk_lvl = flptw_pkg::LvlPml4;
    if (res.fault) begin
      walk_faults++;
    end else if (res.page_size == flptw_pkg::Size1G) begin
      pages_1g++;
    end else if (res.page_size == flptw_pkg::Size2M) begin
      pages_2m++;
    end else begin
      pages_4k++;
    end
    return 1'b1;
  endfunction

  // Sends one item, idling first at random, and predicts its result.
  task automatic send_item(logic kind, logic [flptw_pkg::VAddrW-1:0] va,
                           logic [flptw_pkg::PAddrW-1:0] root,
                           logic [flptw_pkg::EntryW-1:0] data);
    flptw_pkg::result_t res;
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= kind;
    virt_addr_i  <= va;
    root_table_i <= root;
    read_data_i  <= data;
    do @(posedge clk_i); while (!in_ready_o);
    if (predict_walk_step(kind, va, root, data, res)) begin
      pending_results.push_back(res);
      walk_steps++;
    end
  endtask

  task automatic send_request(logic [flptw_pkg::VAddrW-1:0] va,
                              logic [flptw_pkg::PAddrW-1:0] root);
    send_item(flptw_pkg::ReqTranslate, va, root, rand_entry(rand_bit(), rand_bit()));
  endtask

  task automatic send_response(logic [flptw_pkg::EntryW-1:0] data);
    send_item(flptw_pkg::ReqResponse, rand_va(), rand_root(), data);
  endtask

  // Lets every predicted result come out with the input held idle.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Hand-picked walks: every page size, absent top-level and last-level entries, dropped items.
  task automatic test_directed_walks();
    // Full walk to a 4 KiB page; a huge bit on the last level means nothing.
    send_request('0, '0);
    send_response(64'h1);
    send_response(64'h1);
    send_response(64'h1);
    send_response(64'h81);
    // All ones: the top-level huge bit is ignored, then the widest 1 GiB frame.
    send_request('1, '1);
    send_response('1);
    send_response('1);
    // A 2 MiB page with all address bits set.
    send_request('1, rand_root());
    send_response(~64'h80);
    send_response(~64'h80);
    send_response('1);
    // Absent top-level entry with every other bit set.
    send_request(rand_va(), rand_root());
    send_response(64'hFFFF_FFFF_FFFF_FFFE);
    // Absent 4 KiB entry comes back raw.
    send_request(rand_va(), '1);
    send_response(rand_entry(1'b1, 1'b0));
    send_response(rand_entry(1'b1, 1'b0));
    send_response(rand_entry(1'b1, 1'b0));
    send_response(rand_entry(1'b0, 1'b1));
    // A response with no walk in flight is dropped.
    send_response('1);
    // A second request during a walk is dropped.
    send_request(rand_va(), rand_root());
    send_request(rand_va(), rand_root());
    send_response(64'h0);
    wait_for_drain();
  endtask

  // Mostly complete walks with random entries, plus stray items.
  task automatic run_random_walks(int unsigned n_steps, int unsigned gap_pct,
                                  int unsigned stall_pct);
    int unsigned first;
    first = walk_steps;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    while (walk_steps - first < n_steps) begin
      if ($urandom_range(99) < 8) begin
        send_response(rand_entry(rand_bit(), rand_bit()));
      end else begin
        send_request(rand_va(), rand_root());
        while (walk_busy) begin
          if ($urandom_range(99) < 5) begin
            send_request(rand_va(), rand_root());
          end else begin
            send_response(rand_entry($urandom_range(99) < 92, $urandom_range(99) < 25));
          end
        end
      end
    end
    wait_for_drain();
  endtask

  task automatic test_stalled_receiver();
    run_random_walks(400, 20, 71);
  endtask

  task automatic test_sparse_sender();
    run_random_walks(400, 71, 20);
  endtask

  task automatic test_full_rate();
    run_random_walks(400, 0, 0);
  endtask

  task automatic check_field(string name, logic [flptw_pkg::EntryW-1:0] want,
                             logic [flptw_pkg::EntryW-1:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MaxReports) begin
        $display("%t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    end
  endtask

  // Result checker and receiver stalls.
  always @(posedge clk_i) begin
    flptw_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%t: unexpected result, kind %0d read_addr %h phys_addr %h", $time,
                   out_kind_o, read_addr_o, phys_addr_o);
        end
      end else begin
        want = pending_results.pop_front();
        check_field("out_kind", flptw_pkg::EntryW'(want.kind),
                    flptw_pkg::EntryW'(out_kind_o));
        check_field("read_addr", flptw_pkg::EntryW'(want.read_addr),
                    flptw_pkg::EntryW'(read_addr_o));
        check_field("fault", flptw_pkg::EntryW'(want.fault),
                    flptw_pkg::EntryW'(fault_o));
        check_field("phys_addr", flptw_pkg::EntryW'(want.phys_addr),
                    flptw_pkg::EntryW'(phys_addr_o));
        check_field("leaf_entry", want.leaf_entry, leaf_entry_o);
        check_field("page_size", flptw_pkg::EntryW'(want.page_size),
                    flptw_pkg::EntryW'(page_size_o));
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Run time limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%t: run timed out with %0d results outstanding", $time,
               pending_results.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_walks();
    test_stalled_receiver();
    test_sparse_sender();
    test_full_rate();
    $display("Walk steps %0d: %0d 4 KiB, %0d 2 MiB, %0d 1 GiB pages, %0d faults.",
             walk_steps, pages_4k, pages_2m, pages_1g, walk_faults);
    $display("Dropped items %0d, results checked %0d, mismatches %0d.",
             dropped_items, results_checked, errors);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
